// ----- rtl/srst_pkg.sv -----
// Package: types, constants, the sine table builder and the transform helper functions.
`default_nettype none

package srst_pkg;

  // Port field widths
  localparam int AngleW = 12;
  localparam int ScaleW = 16;
  localparam int CoordW = 16;
  localparam int SegIdxW = 3;

  // Phase and sine table geometry
  localparam int PhaseBits = 12;
  localparam int QuarterBits = PhaseBits - 2;
  localparam int QuarterSize = 1 << QuarterBits;
  localparam int RomAddrW = QuarterBits + 1;
  localparam int TrigMagW = 15;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Outline
  localparam int OutlineSegs = 8;
  localparam int SegmentCountDef = 8;
  localparam int OutlineW = 4;

  // Datapath widths
  localparam int RotW = 19;
  localparam int ProdW = 35;
  localparam int RndShift = 22;
  localparam int RndW = ProdW - RndShift + 1;

  typedef logic [AngleW-1:0] phase_t;
  typedef logic [ScaleW-1:0] scale_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [SegIdxW-1:0] seg_idx_t;
  typedef logic signed [OutlineW-1:0] outline_t;
  typedef logic [TrigMagW-1:0] trig_mag_t;
  typedef logic signed [TrigMagW:0] trig_t;
  typedef logic signed [RotW-1:0] rot_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [RndW-1:0] rnd_t;
  typedef logic [QuarterSize:0][TrigMagW-1:0] sin_rom_t;

  typedef struct packed {
    logic                neg;
    logic [RomAddrW-1:0] addr;
  } trig_ref_t;

  localparam outline_t SegX0 [OutlineSegs] =
    '{-4'sd3, 4'sd3, 4'sd3, -4'sd3, -4'sd4, 4'sd0, 4'sd4, 4'sd0};
  localparam outline_t SegY0 [OutlineSegs] =
    '{-4'sd3, -4'sd3, 4'sd3, 4'sd3, 4'sd0, -4'sd4, 4'sd0, 4'sd4};
  localparam outline_t SegX1 [OutlineSegs] =
    '{4'sd3, 4'sd3, -4'sd3, -4'sd3, 4'sd0, 4'sd4, 4'sd0, -4'sd4};
  localparam outline_t SegY1 [OutlineSegs] =
    '{-4'sd3, 4'sd3, 4'sd3, -4'sd3, -4'sd4, 4'sd0, 4'sd4, 4'sd0};

  // sin(k * pi/2 / QuarterSize) in Q1.14, Taylor series to x^11 in Q2.30
  function automatic trig_mag_t quarter_sin(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    x    = (64'(k) * HalfPiQ30) >> QuarterBits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    res  = (sum + 64'd32768) >> 16;
    if (res > 64'd16384) begin
      res = 64'd16384;
    end
    return res[TrigMagW-1:0];
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t rom;
    for (int k = 0; k <= QuarterSize; k++) begin
      rom[RomAddrW'(k)] = quarter_sin(k);
    end
    return rom;
  endfunction

  // Table address and sign for sin (or cos, a quarter turn ahead)
  function automatic trig_ref_t trig_lookup(input phase_t p, input logic cos_sel);
    logic [PhaseBits-1:0]   pp;
    logic [QuarterBits-1:0] r;
    trig_ref_t              t;
    pp = p[PhaseBits-1:0];
    if (cos_sel) begin
      pp = pp + PhaseBits'(QuarterSize);
    end
    r     = pp[QuarterBits-1:0];
    t.neg = pp[PhaseBits-1];
    if (pp[PhaseBits-2]) begin
      t.addr = RomAddrW'(QuarterSize) - {1'b0, r};
    end else begin
      t.addr = {1'b0, r};
    end
    return t;
  endfunction

  function automatic trig_t trig_value(input trig_mag_t mag, input logic neg);
    trig_t v;
    v = {1'b0, mag};
    return neg ? -v : v;
  endfunction

  // a*u - b*w
  function automatic rot_t rot_diff(input outline_t a, input outline_t b,
                                    input trig_t u, input trig_t w);
    logic signed [RotW:0] acc;
    acc = (RotW+1)'(a) * (RotW+1)'(u) - (RotW+1)'(b) * (RotW+1)'(w);
    return acc[RotW-1:0];
  endfunction

  // a*u + b*w
  function automatic rot_t rot_sum(input outline_t a, input outline_t b,
                                   input trig_t u, input trig_t w);
    logic signed [RotW:0] acc;
    acc = (RotW+1)'(a) * (RotW+1)'(u) + (RotW+1)'(b) * (RotW+1)'(w);
    return acc[RotW-1:0];
  endfunction

  // Q14 rotated coordinate times Q4.12 scale gives Q26
  function automatic prod_t scale_mul(input rot_t r, input scale_t s);
    logic signed [ScaleW:0] ss;
    ss = {1'b0, s};
    return ProdW'(r) * ProdW'(ss);
  endfunction

  // Q26 to Q4, half away from zero
  function automatic rnd_t round_q4(input prod_t v);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] sum;
    rnd_t             r;
    mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    sum = mag + (ProdW'(1) << (RndShift - 1));
    r   = {1'b0, sum[ProdW-1:RndShift]};
    return v[ProdW-1] ? -r : r;
  endfunction

  function automatic coord_t sat_add(input rnd_t r, input coord_t loc);
    logic signed [CoordW:0] sum;
    sum = (CoordW+1)'(loc) + (CoordW+1)'(r);
    if (sum > (CoordW+1)'(signed'({1'b0, {(CoordW-1){1'b1}}}))) begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end else if (sum < -(CoordW+1)'(signed'({2'b01, {(CoordW-1){1'b0}}}))) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end
    return sum[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/shape_rotate_scale_translate_unit.sv -----
// Top level: rotate, scale and translate an eight-segment outline, one segment word per cycle
//   while the output does not stall.
// Issue: SegmentCount segments per input word (8 by default), walked by the segment issue
//   counter one segment per cycle while the pipe is not held; the next input word is taken in
//   the cycle the last segment of the current one issues.
// Reset: asynchronous, active low; clears the issue counter and all stage valid bits.
`default_nettype none

module shape_rotate_scale_translate_unit #(
  parameter int SegmentCount = srst_pkg::SegmentCountDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  srst_pkg::phase_t      angle_phase_i,
  input  srst_pkg::scale_t      scale_factor_i,
  input  srst_pkg::coord_t      location_x_i,
  input  srst_pkg::coord_t      location_y_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output srst_pkg::seg_idx_t    segment_index_o,
  output srst_pkg::coord_t      start_x_o,
  output srst_pkg::coord_t      start_y_o,
  output srst_pkg::coord_t      end_x_o,
  output srst_pkg::coord_t      end_y_o,
  output logic                  last_segment_o
);
  import srst_pkg::*;

  // Clamp the segment count to between one and the outline size
  localparam int SegN = (SegmentCount < 1) ? 1 :
                        (SegmentCount > OutlineSegs) ? OutlineSegs : SegmentCount;
  localparam seg_idx_t SegLast = seg_idx_t'(SegN - 1);

  // Quarter-wave sine ROM, built at elaboration and read through a register
  localparam sin_rom_t SinRom = build_sin_rom();

  // Whole pipe holds while a finished word waits at the output
  logic pipe_en;
  assign pipe_en = !(out_valid_o && out_stall_i);

  // ---------------------------------------------------------------------------
  // Issue stage: hold the current input word and walk its segments
  // ---------------------------------------------------------------------------
  phase_t   phase_q;
  scale_t   scale_q;
  coord_t   loc_x_q;
  coord_t   loc_y_q;
  seg_idx_t seg_q;
  logic     busy_q;
  logic     issue;
  logic     last_issue;
  logic     in_accept;

  assign issue      = busy_q && pipe_en;
  assign last_issue = (seg_q == SegLast);
  // Take a new word when idle or while the last segment of the current one issues
  assign in_stall_o = !pipe_en || (busy_q && !last_issue);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seg_q  <= '0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
      seg_q  <= '0;
    end else if (issue) begin
      if (last_issue) begin
        busy_q <= 1'b0;
      end else begin
        seg_q <= seg_q + seg_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      phase_q <= angle_phase_i;
      scale_q <= scale_factor_i;
      loc_x_q <= location_x_i;
      loc_y_q <= location_y_i;
    end
  end

  trig_ref_t sin_ref;
  trig_ref_t cos_ref;
  assign sin_ref = trig_lookup(phase_q, 1'b0);
  assign cos_ref = trig_lookup(phase_q, 1'b1);

  // ---------------------------------------------------------------------------
  // Stage 1: sine table read
  // ---------------------------------------------------------------------------
  logic      v1_q;
  seg_idx_t  seg1_q;
  logic      last1_q;
  scale_t    scale1_q;
  coord_t    loc_x1_q;
  coord_t    loc_y1_q;
  trig_mag_t sin_mag1_q;
  trig_mag_t cos_mag1_q;
  logic      sin_neg1_q;
  logic      cos_neg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg1_q     <= seg_q;
      last1_q    <= last_issue;
      scale1_q   <= scale_q;
      loc_x1_q   <= loc_x_q;
      loc_y1_q   <= loc_y_q;
      sin_mag1_q <= SinRom[sin_ref.addr];
      cos_mag1_q <= SinRom[cos_ref.addr];
      sin_neg1_q <= sin_ref.neg;
      cos_neg1_q <= cos_ref.neg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: rotate both endpoints (constant coordinates, Q14 result)
  // ---------------------------------------------------------------------------
  trig_t    sin_v;
  trig_t    cos_v;
  outline_t x0;
  outline_t y0;
  outline_t x1;
  outline_t y1;

  assign sin_v = trig_value(sin_mag1_q, sin_neg1_q);
  assign cos_v = trig_value(cos_mag1_q, cos_neg1_q);
  assign x0    = SegX0[seg1_q];
  assign y0    = SegY0[seg1_q];
  assign x1    = SegX1[seg1_q];
  assign y1    = SegY1[seg1_q];

  logic     v2_q;
  seg_idx_t seg2_q;
  logic     last2_q;
  scale_t   scale2_q;
  coord_t   loc_x2_q;
  coord_t   loc_y2_q;
  rot_t     rx0_q;
  rot_t     ry0_q;
  rot_t     rx1_q;
  rot_t     ry1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg2_q   <= seg1_q;
      last2_q  <= last1_q;
      scale2_q <= scale1_q;
      loc_x2_q <= loc_x1_q;
      loc_y2_q <= loc_y1_q;
      rx0_q    <= rot_diff(x0, y0, cos_v, sin_v);
      ry0_q    <= rot_sum(x0, y0, sin_v, cos_v);
      rx1_q    <= rot_diff(x1, y1, cos_v, sin_v);
      ry1_q    <= rot_sum(x1, y1, sin_v, cos_v);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale (Q26 products)
  // ---------------------------------------------------------------------------
  logic     v3_q;
  seg_idx_t seg3_q;
  logic     last3_q;
  coord_t   loc_x3_q;
  coord_t   loc_y3_q;
  prod_t    px0_q;
  prod_t    py0_q;
  prod_t    px1_q;
  prod_t    py1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg3_q   <= seg2_q;
      last3_q  <= last2_q;
      loc_x3_q <= loc_x2_q;
      loc_y3_q <= loc_y2_q;
      px0_q    <= scale_mul(rx0_q, scale2_q);
      py0_q    <= scale_mul(ry0_q, scale2_q);
      px1_q    <= scale_mul(rx1_q, scale2_q);
      py1_q    <= scale_mul(ry1_q, scale2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round to Q4, half away from zero
  // ---------------------------------------------------------------------------
  logic     v4_q;
  seg_idx_t seg4_q;
  logic     last4_q;
  coord_t   loc_x4_q;
  coord_t   loc_y4_q;
  rnd_t     qx0_q;
  rnd_t     qy0_q;
  rnd_t     qx1_q;
  rnd_t     qy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (pipe_en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg4_q   <= seg3_q;
      last4_q  <= last3_q;
      loc_x4_q <= loc_x3_q;
      loc_y4_q <= loc_y3_q;
      qx0_q    <= round_q4(px0_q);
      qy0_q    <= round_q4(py0_q);
      qx1_q    <= round_q4(px1_q);
      qy1_q    <= round_q4(py1_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: translate, saturate, and present the output word
  // ---------------------------------------------------------------------------
  logic     v5_q;
  seg_idx_t seg5_q;
  logic     last5_q;
  coord_t   sx_q;
  coord_t   sy_q;
  coord_t   ex_q;
  coord_t   ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (pipe_en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg5_q  <= seg4_q;
      last5_q <= last4_q;
      sx_q    <= sat_add(qx0_q, loc_x4_q);
      sy_q    <= sat_add(qy0_q, loc_y4_q);
      ex_q    <= sat_add(qx1_q, loc_x4_q);
      ey_q    <= sat_add(qy1_q, loc_y4_q);
    end
  end

  assign out_valid_o     = v5_q;
  assign segment_index_o = seg5_q;
  assign start_x_o       = sx_q;
  assign start_y_o       = sy_q;
  assign end_x_o         = ex_q;
  assign end_y_o         = ey_q;
  assign last_segment_o  = last5_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The last-segment flag marks exactly the final segment index
  a_last_matches_index: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_segment_o == (segment_index_o == SegLast))
  ) else $error("last_segment_o disagrees with segment_index_o");

  // A new word is taken only when idle or on the final segment issue
  a_accept_only_at_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && busy_q) |-> (last_issue && pipe_en)
  ) else $error("input word taken while segments remain");

  // An accepted word starts issuing from segment zero
  a_accept_starts_walk: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (busy_q && seg_q == '0)
  ) else $error("segment walk did not restart after accept");

endmodule

`default_nettype wire

// ----- test/tb_shape_rotate_scale_translate_unit.sv -----
// Testbench for the outline rotate, scale and translate unit: predicts and checks segment words.
`timescale 1ns / 1ps

module tb_shape_rotate_scale_translate_unit;
  import srst_pkg::*;

  localparam int OutlineLen  = 8;
  localparam int HoldCycles  = 400;   // long receiver hold-off used to back up the pipe
  localparam int StuckLimit  = 4000;  // cycles with no word moving before the run is abandoned
  localparam int TailCycles  = 24;    // settle time after the last expected word
  localparam int ReportCap   = 100;   // keep the log readable if everything is broken
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Outline endpoints, segment i runs from (start) to (end)
  localparam int StartX [OutlineLen] = '{-3, 3, 3, -3, -4, 0, 4, 0};
  localparam int StartY [OutlineLen] = '{-3, -3, 3, 3, 0, -4, 0, 4};
  localparam int EndX   [OutlineLen] = '{3, 3, -3, -3, 0, 4, 0, -4};
  localparam int EndY   [OutlineLen] = '{-3, 3, 3, -3, -4, 0, 4, 0};

  typedef struct {
    phase_t phase;
    scale_t scale;
    coord_t loc_x;
    coord_t loc_y;
  } pose_word_t;

  typedef struct {
    seg_idx_t idx;
    coord_t   sx;
    coord_t   sy;
    coord_t   ex;
    coord_t   ey;
    logic     is_last;
  } segment_word_t;

  // Clock, reset and DUT-facing signals; every input starts at a known value
  logic     clk_i         = 1'b0;
  logic     rst_ni        = 1'b0;
  logic     in_valid      = 1'b0;
  phase_t   angle_phase   = '0;
  scale_t   scale_factor  = '0;
  coord_t   location_x    = '0;
  coord_t   location_y    = '0;
  logic     out_stall     = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  seg_idx_t segment_index_o;
  coord_t   start_x_o;
  coord_t   start_y_o;
  coord_t   end_x_o;
  coord_t   end_y_o;
  logic     last_segment_o;

  // Poses waiting to be offered, and segment words the block still owes
  pose_word_t    poses_to_send[$];
  segment_word_t segments_due[$];

  // Handshake mix, changed only on the falling edge between phases
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  int unsigned errors      = 0;
  int unsigned poses_in    = 0;
  int unsigned segments_out = 0;
  int unsigned saturations = 0;

  shape_rotate_scale_translate_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .angle_phase_i   (angle_phase),
    .scale_factor_i  (scale_factor),
    .location_x_i    (location_x),
    .location_y_i    (location_y),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .segment_index_o (segment_index_o),
    .start_x_o       (start_x_o),
    .start_y_o       (start_y_o),
    .end_x_o         (end_x_o),
    .end_y_o         (end_y_o),
    .last_segment_o  (last_segment_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Quarter-wave sine entry k in Q1.14: Taylor series to x^11 on a Q2.30 angle,
  // rounded half up, capped at one.
  function automatic int quarter_wave(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned res;
    x    = (longint'(k) * HalfPiQ30) >> (PhaseBits - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    res = (acc + 64'd32768) >> 16;
    if (res > 64'd16384) begin
      res = 64'd16384;
    end
    return int'(res);
  endfunction

  // Fold the phase into the first quadrant, then restore the sign
  function automatic int phase_sine(phase_t p);
    logic [1:0]             quad;
    logic [PhaseBits-3:0]   rem;
    int                     mag;
    quad = p[PhaseBits-1 -: 2];
    rem  = p[PhaseBits-3:0];
    mag  = quad[0] ? quarter_wave((1 << (PhaseBits - 2)) - rem) : quarter_wave(rem);
    return quad[1] ? -mag : mag;
  endfunction

  // Q26 to Q4, ties away from zero
  function automatic int q26_to_q4(longint v);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << 21)) >> 22;
    return (v < 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) begin
      saturations++;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      saturations++;
      return 16'sh8000;
    end
    return coord_t'(v);
  endfunction

  // Rotate one endpoint, scale it, then move it to the location
  function automatic void place_point(input int x, input int y, input int sn, input int cs,
                                      input pose_word_t pose,
                                      output coord_t ox, output coord_t oy);
    int rx;
    int ry;
    rx = x * cs - y * sn;
    ry = x * sn + y * cs;
    ox = clamp_coord(q26_to_q4(longint'(rx) * longint'(pose.scale)) + int'(pose.loc_x));
    oy = clamp_coord(q26_to_q4(longint'(ry) * longint'(pose.scale)) + int'(pose.loc_y));
  endfunction

  // Queue the eight segment words one accepted pose must produce
  function automatic void predict_outline(pose_word_t pose);
    int            sn;
    int            cs;
    segment_word_t w;
    sn = phase_sine(pose.phase);
    cs = phase_sine(phase_t'(pose.phase + phase_t'(1 << (PhaseBits - 2))));
    for (int i = 0; i < OutlineLen; i++) begin
      w.idx     = seg_idx_t'(i);
      place_point(StartX[w.idx], StartY[w.idx], sn, cs, pose, w.sx, w.sy);
      place_point(EndX[w.idx], EndY[w.idx], sn, cs, pose, w.ex, w.ey);
      w.is_last = (i == OutlineLen - 1);
      segments_due.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer the next pose when the slot is free, idle at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_poses
    pose_word_t nxt;
    pose_word_t held;
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      angle_phase  <= '0;
      scale_factor <= '0;
      location_x   <= '0;
      location_y   <= '0;
    end else begin
      // Predict on acceptance, from the word that sat on the port
      if (in_valid && !in_stall_o) begin
        held.phase = angle_phase;
        held.scale = scale_factor;
        held.loc_x = location_x;
        held.loc_y = location_y;
        predict_outline(held);
        poses_in++;
      end
      // Hold a stalled word; otherwise advance or go idle
      if (!in_valid || !in_stall_o) begin
        if (poses_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt           = poses_to_send.pop_front();
          in_valid     <= 1'b1;
          angle_phase  <= nxt.phase;
          scale_factor <= nxt.scale;
          location_x   <= nxt.loc_x;
          location_y   <= nxt.loc_y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_stall
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HoldCycles;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted segment word with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      if (errors <= ReportCap) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : check_segments
    segment_word_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      segments_out++;
      if (segments_due.size() == 0) begin
        errors++;
        if (errors <= ReportCap) begin
          $error("segment word %0d arrived with nothing expected", segment_index_o);
        end
      end else begin
        want = segments_due.pop_front();
        check_field("segment_index", want.idx, segment_index_o);
        check_field("start_x", want.sx, start_x_o);
        check_field("start_y", want.sy, start_y_o);
        check_field("end_x", want.ex, end_x_o);
        check_field("end_y", want.ey, end_y_o);
        check_field("last_segment", want.is_last, last_segment_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: abandon the run when no word moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("timeout: no word moved for %0d cycles", StuckLimit);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_pose(int unsigned p, int unsigned s, int lx, int ly);
    pose_word_t w;
    w.phase = phase_t'(p);
    w.scale = scale_t'(s);
    w.loc_x = coord_t'(lx);
    w.loc_y = coord_t'(ly);
    poses_to_send.push_back(w);
  endfunction

  // Half full-range poses; a quarter near unit scale around a modest location, a quarter near the edges
  function automatic void add_random_pose();
    int unsigned pick;
    pick = $urandom_range(3);
    if (pick == 0) begin
      add_pose($urandom_range(4095), $urandom_range(4096 + 1024, 4096 - 1024),
               $signed($urandom_range(16000)) - 8000, $signed($urandom_range(16000)) - 8000);
    end else if (pick == 1) begin
      // push results toward the edges so saturation shows up
      add_pose($urandom_range(4095), $urandom_range(65535, 49152),
               $urandom_range(1) ? $urandom_range(32767, 31744)
                                 : -$signed($urandom_range(32768, 31744)),
               $urandom_range(1) ? $urandom_range(32767, 31744)
                                 : -$signed($urandom_range(32768, 31744)));
    end else begin
      add_pose($urandom_range(4095), $urandom_range(65535),
               $signed($urandom_range(65535)) - 32768, $signed($urandom_range(65535)) - 32768);
    end
  endfunction

  // Wait until every pose is taken and every segment word has come back
  task automatic drain();
    while (poses_to_send.size() != 0 || in_valid || segments_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_mix(int unsigned idle, int unsigned stall);
    @(negedge clk_i);
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  initial begin : run
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quadrant boundaries, scale and location extremes, saturation both ways
    set_mix(0, 0);
    add_pose(0, 4096, 0, 0);
    add_pose(1024, 4096, 0, 0);
    add_pose(2048, 4096, 0, 0);
    add_pose(3072, 4096, 0, 0);
    add_pose(4095, 65535, 0, 0);
    add_pose(512, 65535, 0, 0);
    add_pose(1, 1, 0, 0);
    add_pose(1023, 0, 32767, -32768);
    add_pose(1025, 65535, 32767, 32767);
    add_pose(2560, 65535, -32768, -32768);
    add_pose(3583, 65535, -32768, 32767);
    add_pose(2047, 32768, 16, -16);
    add_pose(12'hAAA, 16'h5555, 16'sh5555, -16'sh5556);
    add_pose(12'h555, 16'hAAAA, -16'sh5556, 16'sh5555);
    add_pose(341, 2048, 0, 0);
    add_pose(3072, 1, -1, -1);
    add_pose(2048, 2, 0, 0);
    add_pose(3071, 65535, 32700, -32700);
    drain();

    // Random poses under four handshake mixes
    set_mix(0, 0);
    repeat (88) add_random_pose();
    drain();
    set_mix(77, 0);
    repeat (88) add_random_pose();
    drain();
    set_mix(0, 77);
    repeat (88) add_random_pose();
    drain();
    set_mix(26, 26);
    repeat (88) add_random_pose();
    drain();

    // Back-pressure: hold the output off while the sender keeps offering
    set_mix(0, 0);
    hold_requests++;
    repeat (40) add_random_pose();
    drain();

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d poses and %0d segment words (%0d saturated coordinates)",
             poses_in, segments_out, saturations);
    $display("idling mixes: none, sender 77%%, receiver 77%%, both 26%%, long output hold-off");
    if (errors == 0 && segments_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d segment words missing", errors, segments_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
